@@ rtl/core/lsmu_pkg.sv @@
// ----------------------------------------------------------------------------
// lsmu_pkg
// Shared types, codes and arithmetic helpers of the log semiring message
// update unit: Q19.12 saturating add and the log-add-exp correction table.
// ----------------------------------------------------------------------------
package lsmu_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned CorrW  = 12;

	typedef logic signed [ValueW-1:0] lval_t;

	localparam lval_t NegInf = 32'sh8000_0000;
	localparam lval_t PosMax = 32'sh7fff_ffff;

	localparam logic [63:0] One30 = 64'd1 << 30;

	localparam logic [1:0] MODE_TABLE = 2'd0;
	localparam logic [1:0] MODE_BASE  = 2'd1;
	localparam logic [1:0] MODE_ELEM  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] row;
		logic [3:0] col;
		lval_t      value;
		logic       last;
	} lsmu_item_t;

	typedef struct packed {
		logic [3:0] out_row;
		lval_t      message;
		lval_t      total;
		logic       run_end;
	} lsmu_result_t;

	typedef logic [4:0] lsmu_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD
	} lsmu_state_t;

	// saturating add, negative infinity absorbs
	function automatic lval_t sat_add(lval_t a, lval_t b);
		logic signed [ValueW:0] s;
		s = $signed({a[ValueW-1], a}) + $signed({b[ValueW-1], b});
		if (a == NegInf || b == NegInf) begin
			return NegInf;
		end
		if (s[ValueW] != s[ValueW-1]) begin
			return s[ValueW] ? NegInf : PosMax;
		end
		return s[ValueW-1:0];
	endfunction

	// restoring unsigned divide, used for table constants only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-f) for f in [0, 1] in Q2.30
	function automatic logic [63:0] exp_neg_frac_q30(logic [63:0] f);
		logic signed [63:0] sum;
		logic [63:0]        term;
		sum  = $signed(One30);
		term = One30;
		for (int k = 1; k <= 24; k++) begin
			term = udiv64((term * f) >> 30, 64'(k));
			if (k[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return (sum < 0) ? 64'd0 : 64'(sum);
	endfunction

	function automatic logic [63:0] exp_neg_q30(logic [63:0] xq);
		logic [63:0] whole;
		logic [63:0] r;
		logic [63:0] e1;
		whole = xq >> 30;
		r     = exp_neg_frac_q30(xq & (One30 - 64'd1));
		e1    = exp_neg_frac_q30(One30);
		for (int n = 0; n < 16; n++) begin
			if (64'(n) < whole) begin
				r = (r * e1) >> 30;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] ln1p_q30(logic [63:0] y);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] sum;
		z   = udiv64(y << 30, (One30 << 1) + y);
		z2  = (z * z) >> 30;
		p   = z;
		sum = 64'd0;
		for (int k = 0; k < 24; k++) begin
			sum = sum + udiv64(p, 64'(2 * k + 1));
			p   = (p * z2) >> 30;
		end
		return sum << 1;
	endfunction

	// correction ln(1 + exp(-x)) in Q12, x given in Q34.30
	function automatic logic [CorrW-1:0] corr_entry(logic [63:0] xq);
		logic [63:0] l;
		l = ln1p_q30(exp_neg_q30(xq));
		return CorrW'((l + (64'd1 << 17)) >> 18);
	endfunction

endpackage

@@ rtl/core/lsmu_stream_if.sv @@
// ----------------------------------------------------------------------------
// lsmu_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lsmu_stream_if #(
	parameter type data_t = logic
);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (
		output valid,
		output data,
		input  ready
	);

	modport sink (
		input  valid,
		input  data,
		output ready
	);

endinterface

@@ rtl/core/lsmu_lae_unit.sv @@
// ----------------------------------------------------------------------------
// lsmu_lae_unit
// Three-stage shared log-add-exp datapath: table plus element, max and
// distance, then max plus table correction with saturation.
// ----------------------------------------------------------------------------
module lsmu_lae_unit #(
	parameter int CORR_TABLE_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  lsmu_pkg::lval_t tab,
	input  lsmu_pkg::lval_t elem,
	input  lsmu_pkg::lval_t acc,
	output logic           busy,
	output logic           res_vld,
	output lsmu_pkg::lval_t res
);
	import lsmu_pkg::*;

	localparam int IdxW  = $clog2(CORR_TABLE_DEPTH);
	localparam int ProdW = 16 + $clog2(CORR_TABLE_DEPTH + 1);

	logic [CorrW-1:0] corr_rom [CORR_TABLE_DEPTH];

	for (genvar g = 0; g < CORR_TABLE_DEPTH; g++) begin : g_corr
		localparam logic [63:0]      Xq = udiv64((64'(g) * 64'd16) << 30,
			64'(CORR_TABLE_DEPTH));
		localparam logic [CorrW-1:0] Cv = corr_entry(Xq);
		assign corr_rom[g] = Cv;
	end

	logic             vld_s1, vld_s2, vld_s3;
	lval_t            t_s1, acc_s1;
	lval_t            m_s2;
	logic             near_s2;
	logic [IdxW-1:0]  idx_s2;
	lval_t            res_s3;

	lval_t             m, n;
	logic [ValueW:0]   d;
	logic [ProdW-1:0]  prod;
	logic signed [ValueW:0] s3_sum;

	always_comb begin
		if (acc_s1 > t_s1) begin
			m = acc_s1;
			n = t_s1;
		end else begin
			m = t_s1;
			n = acc_s1;
		end
		d    = $unsigned($signed({m[ValueW-1], m}) - $signed({n[ValueW-1], n}));
		prod = ProdW'(d[15:0]) * ProdW'(CORR_TABLE_DEPTH);
	end

	assign s3_sum = $signed({m_s2[ValueW-1], m_s2})
		+ $signed({(ValueW + 1 - CorrW)'(0), corr_rom[idx_s2]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= sat_add(tab, elem);
		acc_s1  <= acc;
		m_s2    <= m;
		near_s2 <= (n != NegInf) && (d[ValueW:16] == '0);
		idx_s2  <= prod[16 +: IdxW];
		if (!near_s2) begin
			res_s3 <= m_s2;
		end else if (s3_sum[ValueW] != s3_sum[ValueW-1]) begin
			res_s3 <= PosMax;
		end else begin
			res_s3 <= s3_sum[ValueW-1:0];
		end
	end

	assign busy    = vld_s1 | vld_s2;
	assign res_vld = vld_s3;
	assign res     = res_s3;

endmodule

@@ rtl/core/log_semiring_message_update_unit.sv @@
// ----------------------------------------------------------------------------
// log_semiring_message_update_unit
// Log-domain upward message pass: log-sum-exp matrix-vector product over a
// loaded transition table, with per-row base accumulators.
// ----------------------------------------------------------------------------
// Table writes, base writes and unused mode codes are taken in the idle state. A
// message element is folded by one shared three-stage log-add-exp pipeline
// that takes one active row per cycle from the single-read transition table
// and running-sum memories; each row passes a read stage, then the pipeline,
// and the unit waits for the pipeline to drain. On an element marked last
// the unit then emits one result per active row, each through a read state
// and a load state that waits while the result sink holds ready low; a result
// may still wait in the output register while the next item is taken.
// Running sums return to negative infinity at once after the last result.
module log_semiring_message_update_unit #(
	parameter int MAX_ROWS         = 16,
	parameter int MAX_COLS         = 16,
	parameter int CORR_TABLE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	lsmu_stream_if.sink   in_item,
	lsmu_stream_if.source out_result,
	lsmu_stream_if.sink   cfg
);
	import lsmu_pkg::*;

	localparam int RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int TabDepth = MAX_ROWS * MAX_COLS;
	localparam int TabAw    = (TabDepth > 1) ? $clog2(TabDepth) : 1;

	lsmu_state_t state_q, state_d;

	lsmu_cfg_t       rows_q;
	logic [RowW-1:0] act_last;
	logic [RowW-1:0] row_q;
	logic [3:0]      col_q;
	lval_t           elem_q;
	logic            last_q;

	lval_t           tab_mem [TabDepth];
	lval_t           tab_rd_q;
	lval_t           sum_mem [MAX_ROWS];
	lval_t           sum_rd_q;
	logic            sum_ok_q;
	logic [MAX_ROWS-1:0] sum_vld_q;
	lval_t           base_mem [MAX_ROWS];
	lval_t           base_rd_q;
	logic            base_ok_q;
	logic [MAX_ROWS-1:0] base_vld_q;

	logic            rd_vld_q;
	logic [RowW-1:0] rd_row_q, tag_s1, tag_s2, tag_s3;

	logic            in_acc;
	logic            col_ok;
	logic            tab_we, base_we;
	logic [TabAw-1:0] tab_waddr, tab_raddr;
	logic            fold_rd, emit_rd, row_clr, row_inc, out_ld, sum_clr, out_free;

	logic            lae_busy, wb_vld;
	lval_t           wb_res;
	lval_t           msg;

	lval_t           acc_in;

	logic            out_vld_q;
	lsmu_result_t    out_data_q;

	assign cfg.ready  = 1'b1;
	assign in_acc     = in_item.valid && in_item.ready;
	assign col_ok     = 32'(in_item.data.col) < MAX_COLS;
	assign out_free   = !out_vld_q || out_result.ready;
	assign tab_waddr  = TabAw'(32'(in_item.data.row) * MAX_COLS + 32'(in_item.data.col));
	assign tab_raddr  = TabAw'(32'(row_q) * MAX_COLS + 32'(col_q));
	assign tab_we     = in_acc && (in_item.data.mode == MODE_TABLE)
		&& (32'(in_item.data.row) < MAX_ROWS) && col_ok;
	assign base_we    = in_acc && (in_item.data.mode == MODE_BASE)
		&& (32'(in_item.data.row) < MAX_ROWS);

	always_comb begin
		if (rows_q == '0) begin
			act_last = '0;
		end else if (32'(rows_q) > MAX_ROWS) begin
			act_last = RowW'(MAX_ROWS - 1);
		end else begin
			act_last = RowW'(rows_q - 5'd1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_item.ready = 1'b0;
		fold_rd       = 1'b0;
		emit_rd       = 1'b0;
		row_clr       = 1'b0;
		row_inc       = 1'b0;
		out_ld        = 1'b0;
		sum_clr       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_item.ready = 1'b1;
				row_clr       = 1'b1;
				if (in_item.valid && in_item.data.mode == MODE_ELEM) begin
					if (col_ok) begin
						state_d = ST_FOLD;
					end else if (in_item.data.last) begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_FOLD: begin
				fold_rd = 1'b1;
				if (row_q == act_last) begin
					row_clr = 1'b1;
					state_d = ST_DRAIN;
				end else begin
					row_inc = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_q && !lae_busy && !wb_vld) begin
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				emit_rd = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					out_ld = 1'b1;
					if (row_q == act_last) begin
						sum_clr = 1'b1;
						row_clr = 1'b1;
						state_d = ST_IDLE;
					end else begin
						row_inc = 1'b1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= 5'd16;
			row_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				rows_q <= cfg.data;
			end
			if (row_clr) begin
				row_q <= '0;
			end else if (row_inc) begin
				row_q <= row_q + RowW'(1);
			end
			rd_vld_q <= fold_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q  <= in_item.data.col;
			elem_q <= in_item.data.value;
			last_q <= in_item.data.last;
		end
		rd_row_q <= row_q;
		tag_s1   <= rd_row_q;
		tag_s2   <= tag_s1;
		tag_s3   <= tag_s2;
	end

	// transition table
	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[tab_waddr] <= in_item.data.value;
		end
		if (fold_rd) begin
			tab_rd_q <= tab_mem[tab_raddr];
		end
	end

	// running sums
	always_ff @(posedge clk) begin
		if (wb_vld) begin
			sum_mem[tag_s3] <= wb_res;
		end
		if (fold_rd || emit_rd) begin
			sum_rd_q <= sum_mem[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q <= '0;
			sum_ok_q  <= 1'b0;
		end else begin
			if (sum_clr) begin
				sum_vld_q <= '0;
			end else if (wb_vld) begin
				sum_vld_q[tag_s3] <= 1'b1;
			end
			if (fold_rd || emit_rd) begin
				sum_ok_q <= sum_vld_q[row_q];
			end
		end
	end

	// row bases
	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[RowW'(in_item.data.row)] <= in_item.data.value;
		end
		if (emit_rd) begin
			base_rd_q <= base_mem[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_vld_q <= '0;
			base_ok_q  <= 1'b0;
		end else begin
			if (base_we) begin
				base_vld_q[RowW'(in_item.data.row)] <= 1'b1;
			end
			if (emit_rd) begin
				base_ok_q <= base_vld_q[row_q];
			end
		end
	end

	assign acc_in = sum_ok_q ? sum_rd_q : NegInf;
	assign msg    = sum_ok_q ? sum_rd_q : NegInf;

	lsmu_lae_unit #(
		.CORR_TABLE_DEPTH(CORR_TABLE_DEPTH)
	) u_lae (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (rd_vld_q),
		.tab    (tab_rd_q),
		.elem   (elem_q),
		.acc    (acc_in),
		.busy   (lae_busy),
		.res_vld(wb_vld),
		.res    (wb_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_ld) begin
			out_vld_q <= 1'b1;
		end else if (out_result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_data_q.out_row <= 4'(row_q);
			out_data_q.message <= msg;
			out_data_q.total   <= sat_add(base_ok_q ? base_rd_q : '0, msg);
			out_data_q.run_end <= (row_q == act_last);
		end
	end

	assign out_result.valid = out_vld_q;
	assign out_result.data  = out_data_q;

	a_out_from_emit : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_EMIT_LD))
		else $error("result beat raised outside emission");

	a_wb_in_fold : assert property (@(posedge clk) disable iff (!arst_n)
		wb_vld |-> (state_q == ST_FOLD || state_q == ST_DRAIN))
		else $error("running sum written back outside fold");

	a_emit_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_LD) |-> (!rd_vld_q && !lae_busy && !wb_vld))
		else $error("fold pipeline active during emission");

	a_run_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD && out_free && row_q == act_last)
		|=> (state_q == ST_IDLE && sum_vld_q == '0 && out_data_q.run_end))
		else $error("run did not close after the last row");

endmodule

@@ tb/tb_log_semiring_message_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_semiring_message_update_unit
// Self-checking bench for the log semiring message update unit. Table, base
// and element beats are streamed in over several row-count settings and idle
// patterns; a cycle-free model of the log-sum-exp fold predicts every result
// beat, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_log_semiring_message_update_unit;

	import lsmu_pkg::*;

	typedef longint unsigned u64_t;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam u64_t       Q30_ONE     = u64_t'(1) << 30;
	localparam int         SETTLE_CYC  = 40;
	localparam int         STALL_LIMIT = 2000;

	typedef struct {
		lsmu_item_t it;
		bit         hold;
	} beat_req_t;

	logic clk;
	logic arst_n;

	lsmu_stream_if #(.data_t(lsmu_item_t))   item_if ();
	lsmu_stream_if #(.data_t(lsmu_result_t)) result_if ();
	lsmu_stream_if #(.data_t(lsmu_cfg_t))    cfg_if ();

	log_semiring_message_update_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (item_if),
		.out_result (result_if),
		.cfg        (cfg_if)
	);

	// model state
	int           corr_q12 [256];
	lval_t        trans_q [16][16];
	lval_t        base_q [16];
	lval_t        sum_q [16];
	lsmu_cfg_t    rows_cfg;
	lsmu_result_t row_results_q [$];

	// stimulus state
	beat_req_t    item_q [$];
	bit           tbl_set [16][16];
	int           gen_rows;
	int           gen_cnt;
	bit           item_held;
	int           send_idle_pct;
	int           recv_stall_pct;

	int           err_cnt;
	int           n_items;
	int           n_results;
	int           n_runs;
	int           n_cfg;
	int           quiet_cyc;
	lsmu_result_t got;
	lsmu_result_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// correction table ln(1 + exp(-x)) in Q12, series math in Q2.30
	function automatic u64_t neg_exp_part(u64_t f);
		longint acc;
		u64_t   term;
		acc  = longint'(Q30_ONE);
		term = Q30_ONE;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * f) >> 30) / u64_t'(k);
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return (acc < 0) ? u64_t'(0) : u64_t'(acc);
	endfunction

	function automatic u64_t neg_exp(u64_t xq);
		u64_t whole;
		u64_t r;
		u64_t e1;
		whole = xq >> 30;
		r     = neg_exp_part(xq & (Q30_ONE - 1));
		e1    = neg_exp_part(Q30_ONE);
		for (u64_t n = 0; n < whole; n++) begin
			r = (r * e1) >> 30;
		end
		return r;
	endfunction

	function automatic u64_t log1p_series(u64_t y);
		u64_t z;
		u64_t z2;
		u64_t p;
		u64_t acc;
		z   = (y << 30) / ((Q30_ONE << 1) + y);
		z2  = (z * z) >> 30;
		p   = z;
		acc = 0;
		for (int k = 0; k < 24; k++) begin
			acc = acc + p / u64_t'(2 * k + 1);
			p   = (p * z2) >> 30;
		end
		return acc << 1;
	endfunction

	function automatic lval_t q_add(lval_t a, lval_t b);
		longint s;
		if (a == NegInf || b == NegInf) begin
			return NegInf;
		end
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647) begin
			s = 64'sd2147483647;
		end
		if (s < -64'sd2147483648) begin
			s = -64'sd2147483648;
		end
		return lval_t'(s);
	endfunction

	function automatic lval_t log_add(lval_t a, lval_t b);
		lval_t  hi;
		lval_t  lo;
		u64_t   gap;
		longint s;
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		if (lo == NegInf) begin
			return hi;
		end
		gap = u64_t'(longint'(hi) - longint'(lo));
		if ((gap >> 8) >= 256) begin
			return hi;
		end
		s = longint'(hi) + longint'(corr_q12[gap >> 8]);
		if (s > 64'sd2147483647) begin
			s = 64'sd2147483647;
		end
		return lval_t'(s);
	endfunction

	task automatic fold_item(lsmu_item_t it);
		int           act;
		lsmu_result_t res;
		act = int'(rows_cfg);
		if (act < 1) begin
			act = 1;
		end
		if (act > 16) begin
			act = 16;
		end
		case (it.mode)
			MODE_TABLE: trans_q[it.row][it.col] = it.value;
			MODE_BASE:  base_q[it.row] = it.value;
			MODE_ELEM: begin
				for (int r = 0; r < act; r++) begin
					sum_q[r] = log_add(sum_q[r], q_add(trans_q[r][it.col], it.value));
				end
				if (it.last) begin
					for (int r = 0; r < act; r++) begin
						res.out_row = 4'(r);
						res.message = sum_q[r];
						res.total   = q_add(base_q[r], sum_q[r]);
						res.run_end = (r == act - 1);
						row_results_q.push_back(res);
					end
					for (int r = 0; r < 16; r++) begin
						sum_q[r] = NegInf;
					end
					n_runs++;
				end
			end
			default: ;
		endcase
	endtask

	function automatic lval_t rand_lval();
		case ($urandom_range(0, 11))
			0:       return NegInf;
			1:       return PosMax - lval_t'($urandom_range(0, 70000));
			2:       return NegInf + lval_t'($urandom_range(1, 70000));
			3, 4:    return lval_t'($urandom);
			default: return lval_t'(int'($urandom_range(0, 80000)) - 40000);
		endcase
	endfunction

	function automatic int pick_col();
		return ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 3))
			: int'($urandom_range(0, 15));
	endfunction

	task automatic push_item(logic [1:0] mode, int r, int c, lval_t v, bit last,
		bit hold = 1'b0);
		beat_req_t b;
		b.it.mode  = mode;
		b.it.row   = 4'(r);
		b.it.col   = 4'(c);
		b.it.value = v;
		b.it.last  = last;
		b.hold     = hold;
		if (mode == MODE_TABLE) begin
			tbl_set[r][c] = 1'b1;
		end
		if (mode != MODE_UNUSED) begin
			gen_cnt++;
		end
		item_q.push_back(b);
	endtask

	// fill any active-row entry of the column that was never written
	task automatic push_elem(int c, lval_t v, bit last, bit hold = 1'b0);
		for (int r = 0; r < gen_rows; r++) begin
			if (!tbl_set[r][c]) begin
				push_item(MODE_TABLE, r, c, rand_lval(), 1'($urandom_range(0, 1)));
			end
		end
		push_item(MODE_ELEM, $urandom_range(0, 15), c, v, last, hold);
	endtask

	task automatic gen_phase(int n_beats, bit with_hold);
		int start;
		int runlen;
		bit held;
		start = gen_cnt;
		held  = 1'b0;
		while (gen_cnt - start < n_beats) begin
			case ($urandom_range(0, 9))
				0: push_item(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
					lval_t'($urandom), 1'($urandom_range(0, 1)));
				1: push_item(MODE_BASE, $urandom_range(0, 15), $urandom_range(0, 15),
					rand_lval(), 1'($urandom_range(0, 1)));
				2: begin
					repeat ($urandom_range(1, 4)) begin
						push_item(MODE_TABLE, $urandom_range(0, 15), pick_col(), rand_lval(),
							1'($urandom_range(0, 1)));
					end
				end
				3: begin
					// open run, closed by a later observation
					repeat ($urandom_range(1, 2)) begin
						push_elem(pick_col(), rand_lval(), 1'b0);
					end
				end
				default: begin
					runlen = $urandom_range(1, 5);
					for (int i = 0; i < runlen; i++) begin
						if (with_hold && !held && (gen_cnt - start > n_beats / 2)) begin
							push_elem(pick_col(), rand_lval(), i == runlen - 1, 1'b1);
							held = 1'b1;
						end else begin
							push_elem(pick_col(), rand_lval(), i == runlen - 1);
						end
					end
				end
			endcase
		end
	endtask

	task automatic settle();
		while (item_q.size() != 0 || item_held || row_results_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_rows(lsmu_cfg_t v);
		@(negedge clk);
		cfg_if.data  <= v;
		cfg_if.valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		rows_cfg = v;
		gen_rows = (v < 1) ? 1 : ((v > 16) ? 16 : int'(v));
		n_cfg++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic report(string what, longint exp_v, longint act_v);
		err_cnt++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
	endtask

	// item driver
	always @(negedge clk) begin
		if (arst_n && !item_held) begin
			if (item_q.size() != 0 && !(item_q[0].hold && row_results_q.size() != 0)
				&& $urandom_range(0, 99) >= send_idle_pct) begin
				item_if.data  <= item_q[0].it;
				item_if.valid <= 1'b1;
				item_held = 1'b1;
				void'(item_q.pop_front());
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (item_if.valid && item_if.ready) begin
			fold_item(item_if.data);
			item_held = 1'b0;
			n_items++;
		end
	end

	// result sink
	always @(negedge clk) begin
		result_if.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			got = result_if.data;
			n_results++;
			if (row_results_q.size() == 0) begin
				report("unexpected result beat, out_row", -1, longint'(got.out_row));
			end else begin
				want = row_results_q.pop_front();
				if (got.out_row !== want.out_row) begin
					report("out_row", longint'(want.out_row), longint'(got.out_row));
				end
				if (got.message !== want.message) begin
					report("message", longint'(want.message), longint'(got.message));
				end
				if (got.total !== want.total) begin
					report("total", longint'(want.total), longint'(got.total));
				end
				if (got.run_end !== want.run_end) begin
					report("run_end", longint'(want.run_end), longint'(got.run_end));
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			quiet_cyc = 0;
		end else begin
			quiet_cyc++;
			if (quiet_cyc >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
					quiet_cyc, row_results_q.size());
				$display("log_semiring_message_update_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		item_if.valid   = 1'b0;
		item_if.data    = '0;
		result_if.ready = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.data     = '0;
		arst_n          = 1'b0;
		item_held       = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		err_cnt         = 0;
		n_items         = 0;
		n_results       = 0;
		n_runs          = 0;
		n_cfg           = 0;
		quiet_cyc       = 0;
		gen_cnt         = 0;
		rows_cfg        = 5'd16;
		gen_rows        = 16;
		for (int i = 0; i < 256; i++) begin
			corr_q12[i] = int'((log1p_series(neg_exp((u64_t'(i * 16) << 30) / 256))
				+ (u64_t'(1) << 17)) >> 18);
		end
		for (int r = 0; r < 16; r++) begin
			base_q[r] = '0;
			sum_q[r]  = NegInf;
			for (int c = 0; c < 16; c++) begin
				trans_q[r][c] = '0;
				tbl_set[r][c] = 1'b0;
			end
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: extremes, saturation, empty runs, correction edge
		write_rows(5'd2);
		push_item(MODE_TABLE, 0, 0, '0, 1'b0);
		push_item(MODE_TABLE, 1, 0, NegInf, 1'b1);
		push_item(MODE_TABLE, 0, 15, PosMax, 1'b0);
		push_item(MODE_TABLE, 1, 15, NegInf + 1, 1'b1);
		push_item(MODE_TABLE, 0, 1, '0, 1'b0);
		push_item(MODE_TABLE, 1, 1, -32'sd4096, 1'b0);
		push_item(MODE_BASE, 0, 15, PosMax, 1'b1);
		push_item(MODE_BASE, 1, 0, NegInf + 1, 1'b0);
		push_item(MODE_BASE, 15, 5, -32'sd1, 1'b0);
		push_item(MODE_UNUSED, 9, 6, lval_t'($urandom), 1'b1);
		push_elem(0, '0, 1'b0);
		push_elem(0, '0, 1'b0);
		push_elem(15, PosMax, 1'b0);
		push_elem(15, NegInf, 1'b1);
		// wait for every pending result before this beat
		push_elem(15, NegInf + 1, 1'b1, 1'b1);
		push_elem(0, NegInf, 1'b1);
		push_elem(1, '0, 1'b0);
		push_elem(1, 32'sd65535, 1'b0);
		push_elem(1, -32'sd70000, 1'b1);
		settle();

		write_rows(5'd16);
		gen_phase(30, 1'b0);
		settle();

		write_rows(5'd1);
		send_idle_pct = 85;
		gen_phase(25, 1'b0);
		settle();

		write_rows(5'd31);
		send_idle_pct  = 0;
		recv_stall_pct = 85;
		gen_phase(25, 1'b0);
		settle();

		write_rows(5'd7);
		send_idle_pct  = 19;
		recv_stall_pct = 19;
		gen_phase(25, 1'b1);
		settle();

		write_rows(5'd0);
		gen_phase(20, 1'b0);
		settle();

		write_rows(5'd16);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		gen_phase(30, 1'b0);
		settle();

		$display("covered %0d input beats and %0d result beats in %0d element runs",
			n_items, n_results, n_runs);
		$display("over %0d row-count settings, %0d mismatches", n_cfg, err_cnt);
		if (err_cnt == 0) begin
			$display("log_semiring_message_update_unit test passed");
		end else begin
			$display("log_semiring_message_update_unit test failed");
		end
		$finish;
	end

endmodule
